// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// Needs a clock and an active-high reset at each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked at every rising edge outside reset.
`define ASSERT_PROP(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never hold at a rising edge outside reset.
`define ASSERT_NEVER(name, clk, rst, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(name, clk, rst, prop, msg)
`define ASSERT_NEVER(name, clk, rst, expr, msg)

`endif

`endif

// ===== src/pwmp_pkg.sv =====
// Shared types and constants for the peer-wire message parser.
// No dependencies.
package pwmp_pkg;

  localparam int MAP_BYTES_DEF = 256;

  // handshake layout
  localparam logic [7:0] HS_PSTRLEN  = 8'd19;
  localparam logic [6:0] HS_PROTO_END = 7'd19;
  localparam logic [6:0] HS_HASH_BEG = 7'd28;
  localparam logic [6:0] HS_HASH_END = 7'd48;
  localparam logic [6:0] HS_LAST     = 7'd67;

  // configuration register indexes
  localparam logic [1:0] REG_HASH_HI  = 2'd0;
  localparam logic [1:0] REG_HASH_MID = 2'd1;
  localparam logic [1:0] REG_HASH_LO  = 2'd2;

  // message type codes
  localparam logic [3:0] MT_CHOKE      = 4'd0;
  localparam logic [3:0] MT_UNCHOKE    = 4'd1;
  localparam logic [3:0] MT_INTERESTED = 4'd2;
  localparam logic [3:0] MT_NOTINTER   = 4'd3;
  localparam logic [3:0] MT_HAVE       = 4'd4;
  localparam logic [3:0] MT_BITFIELD   = 4'd5;
  localparam logic [7:0] MT_MAX        = 8'd8;

  // event codes
  localparam logic [3:0] EV_NONE      = 4'd0;
  localparam logic [3:0] EV_HS_OK     = 4'd1;
  localparam logic [3:0] EV_KEEPALIVE = 4'd2;
  localparam logic [3:0] EV_MSG_BASE  = 4'd3;
  localparam logic [3:0] EV_ERROR     = 4'd12;

  typedef enum logic [2:0] {
    PH_HANDSHAKE,
    PH_LENGTH,
    PH_TYPE,
    PH_PAYLOAD,
    PH_FAILED
  } phase_t;

  // "BitTorrent protocol"
  function automatic logic [7:0] proto_byte(input logic [4:0] idx);
    logic [7:0] ch;
    unique case (idx)
      5'd0:    ch = 8'h42;
      5'd1:    ch = 8'h69;
      5'd2:    ch = 8'h74;
      5'd3:    ch = 8'h54;
      5'd4:    ch = 8'h6f;
      5'd5:    ch = 8'h72;
      5'd6:    ch = 8'h72;
      5'd7:    ch = 8'h65;
      5'd8:    ch = 8'h6e;
      5'd9:    ch = 8'h74;
      5'd10:   ch = 8'h20;
      5'd11:   ch = 8'h70;
      5'd12:   ch = 8'h72;
      5'd13:   ch = 8'h6f;
      5'd14:   ch = 8'h74;
      5'd15:   ch = 8'h6f;
      5'd16:   ch = 8'h63;
      5'd17:   ch = 8'h6f;
      5'd18:   ch = 8'h6c;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== src/peer_wire_message_parser_unit.sv =====
// Peer-wire receive parser: handshake check, message framing, piece map.
// Depends on pwmp_pkg and assert_macros.svh.
//
// Takes one received byte per clock and returns one result per byte, in the
// cycle after the byte is taken, through a single output register; a new
// byte is taken in the same cycle the pending result leaves, so the block
// runs at one byte per clock unless the result side stalls. The piece map
// lives in a MAP_BYTES-deep memory with a registered read: a have
// message reads its map byte on its last byte and writes the updated byte
// back on the next clock; bitfield payload bytes are written directly.
// Per-entry valid flops make reset and the bitfield clear immediate, so no
// clearing pass is needed. The info hash registers are written through the
// cfg port, which is always ready.
`include "assert_macros.svh"

module peer_wire_message_parser_unit
  import pwmp_pkg::*;
#(
  parameter int MAP_BYTES = MAP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  in_byte,
  output logic        event_valid,
  input  logic        event_stall,
  output logic [3:0]  event_res,
  output logic        peer_choking,
  output logic        peer_interested,
  output logic [31:0] have_index,
  output logic        failed
);

  localparam int MAP_AW   = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int PCNT_MAX = (MAP_BYTES > 4) ? MAP_BYTES : 4;
  localparam int PCNT_W   = $clog2(PCNT_MAX + 1);

  // configuration
  logic [63:0]  hash_hi;
  logic [63:0]  hash_mid;
  logic [31:0]  hash_lo;
  logic [159:0] hash_all;

  // parse state
  phase_t            phase, phase_next;
  logic [6:0]        cnt, cnt_next;
  logic [PCNT_W-1:0] pcnt, pcnt_next;
  logic [31:0]       msg_length, msg_length_next;
  logic [31:0]       remain, remain_next;
  logic [3:0]        msg_type, msg_type_next;
  logic [31:0]       index_accum, index_accum_next;
  logic [31:0]       last_have, last_have_next;
  logic              choked, choked_next;
  logic              interest, interest_next;
  logic              mismatch, mismatch_next;

  logic       accept;
  logic [3:0] ev;
  logic       finish;
  logic       hs_bad;
  logic [4:0] hash_idx;
  logic [7:0] hash_base;

  // map requests
  logic              map_rd;
  logic [MAP_AW-1:0] map_rd_addr;
  logic [7:0]        map_mask;
  logic              bf_wr;
  logic [MAP_AW-1:0] bf_addr;
  logic              bf_clear;

  // map memory and writeback stage
  logic [7:0]           map_mem [MAP_BYTES];
  logic [MAP_BYTES-1:0] map_vld;
  logic [7:0]           rd_data;
  logic                 rd_vld;
  logic                 wb_pend;
  logic [MAP_AW-1:0]    wb_addr;
  logic [7:0]           wb_mask;
  logic [7:0]           wb_data;

  assign cfg_ready  = 1'b1;
  assign byte_stall = event_valid && event_stall;
  assign accept     = byte_valid && !byte_stall;
  assign hash_all   = {hash_hi, hash_mid, hash_lo};

  assign peer_choking    = choked;
  assign peer_interested = interest;
  assign have_index      = last_have;
  assign failed          = (phase == PH_FAILED);

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_hi  <= '0;
      hash_mid <= '0;
      hash_lo  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HASH_HI:  hash_hi  <= cfg_data;
        REG_HASH_MID: hash_mid <= cfg_data;
        REG_HASH_LO:  hash_lo  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign hash_idx  = 5'(cnt - HS_HASH_BEG);
  assign hash_base = 8'd159 - {hash_idx, 3'b000};

  always_comb begin
    phase_next       = phase;
    cnt_next         = cnt;
    pcnt_next        = pcnt;
    msg_length_next  = msg_length;
    remain_next      = remain;
    msg_type_next    = msg_type;
    index_accum_next = index_accum;
    last_have_next   = last_have;
    choked_next      = choked;
    interest_next    = interest;
    mismatch_next    = mismatch;
    ev               = EV_NONE;
    finish           = 1'b0;
    hs_bad           = 1'b0;
    map_rd           = 1'b0;
    bf_wr            = 1'b0;
    bf_addr          = pcnt[MAP_AW-1:0];
    bf_clear         = 1'b0;

    unique case (phase)
      PH_HANDSHAKE: begin
        if (cnt == '0) begin
          hs_bad = (in_byte != HS_PSTRLEN);
        end else if (cnt <= HS_PROTO_END) begin
          hs_bad = (in_byte != proto_byte(5'(cnt - 7'd1)));
        end else if (cnt >= HS_HASH_BEG && cnt < HS_HASH_END) begin
          hs_bad = (in_byte != hash_all[hash_base -: 8]);
        end
        mismatch_next = mismatch || hs_bad;
        if (cnt == HS_LAST) begin
          cnt_next = '0;
          if (mismatch_next) begin
            phase_next = PH_FAILED;
            ev         = EV_ERROR;
          end else begin
            phase_next = PH_LENGTH;
            ev         = EV_HS_OK;
          end
        end else begin
          cnt_next = cnt + 7'd1;
        end
      end
      PH_LENGTH: begin
        msg_length_next = {msg_length[23:0], in_byte};
        if (cnt == 7'd3) begin
          cnt_next = '0;
          if (msg_length_next == '0) begin
            ev = EV_KEEPALIVE;
          end else begin
            phase_next = PH_TYPE;
          end
        end else begin
          cnt_next = cnt + 7'd1;
        end
      end
      PH_TYPE: begin
        index_accum_next = '0;
        pcnt_next        = '0;
        msg_type_next    = in_byte[3:0];
        if (in_byte > MT_MAX) begin
          phase_next = PH_FAILED;
          ev         = EV_ERROR;
        end else begin
          bf_clear    = (in_byte[3:0] == MT_BITFIELD);
          remain_next = msg_length - 32'd1;
          if (msg_length == 32'd1) begin
            finish = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        if (msg_type == MT_HAVE && pcnt < PCNT_W'(4)) begin
          index_accum_next = {index_accum[23:0], in_byte};
        end
        if (msg_type == MT_BITFIELD && pcnt < PCNT_W'(MAP_BYTES)) begin
          bf_wr = 1'b1;
        end
        if (pcnt < PCNT_W'(PCNT_MAX)) begin
          pcnt_next = pcnt + PCNT_W'(1);
        end
        remain_next = remain - 32'd1;
        finish      = (remain == 32'd1);
      end
      PH_FAILED: ;
      default: phase_next = PH_FAILED;
    endcase

    // index includes the byte taken this cycle
    map_rd_addr = index_accum_next[MAP_AW+2:3];
    map_mask    = 8'h80 >> index_accum_next[2:0];

    if (finish) begin
      ev         = EV_MSG_BASE + msg_type_next;
      phase_next = PH_LENGTH;
      cnt_next   = '0;
      case (msg_type_next)
        MT_CHOKE:      choked_next   = 1'b1;
        MT_UNCHOKE:    choked_next   = 1'b0;
        MT_INTERESTED: interest_next = 1'b1;
        MT_NOTINTER:   interest_next = 1'b0;
        MT_HAVE: begin
          last_have_next = index_accum_next;
          map_rd         = (index_accum_next[31:3] < 29'(MAP_BYTES));
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HANDSHAKE;
      cnt         <= '0;
      pcnt        <= '0;
      msg_length  <= '0;
      remain      <= '0;
      msg_type    <= '0;
      index_accum <= '0;
      last_have   <= '0;
      choked      <= 1'b1;
      interest    <= 1'b0;
      mismatch    <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      cnt         <= cnt_next;
      pcnt        <= pcnt_next;
      msg_length  <= msg_length_next;
      remain      <= remain_next;
      msg_type    <= msg_type_next;
      index_accum <= index_accum_next;
      last_have   <= last_have_next;
      choked      <= choked_next;
      interest    <= interest_next;
      mismatch    <= mismatch_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (accept) begin
      event_valid <= 1'b1;
    end else if (!event_stall) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      event_res <= ev;
    end
  end

  // Map read-modify-write. The writeback lands in the clock after the read and
  // the next map access is at least four bytes later (a new length prefix),
  // so a read never sees a stale entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_pend <= 1'b0;
    end else begin
      wb_pend <= accept && map_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && map_rd) begin
      rd_data <= map_mem[map_rd_addr];
      rd_vld  <= map_vld[map_rd_addr];
      wb_addr <= map_rd_addr;
      wb_mask <= map_mask;
    end
  end

  assign wb_data = (rd_vld ? rd_data : 8'h00) | wb_mask;

  always_ff @(posedge clk) begin
    if (wb_pend) begin
      map_mem[wb_addr] <= wb_data;
    end else if (accept && bf_wr) begin
      map_mem[bf_addr] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_vld <= '0;
    end else if (accept && bf_clear) begin
      map_vld <= '0;
    end else if (wb_pend) begin
      map_vld[wb_addr] <= 1'b1;
    end else if (accept && bf_wr) begin
      map_vld[bf_addr] <= 1'b1;
    end
  end

  `ASSERT_NEVER(a_map_port_conflict, clk, rst, wb_pend && accept && (bf_wr || bf_clear || map_rd), "map writeback collides with another map access")
  `ASSERT_PROP(a_failed_sticky, clk, rst, (phase == PH_FAILED) |=> (phase == PH_FAILED), "failed phase left without reset")
  `ASSERT_PROP(a_error_fails, clk, rst, (event_valid && event_res == EV_ERROR) |-> failed, "error result without failed state")
  `ASSERT_PROP(a_result_held, clk, rst, (event_valid && event_stall) |=> (event_valid && $stable(event_res)), "stalled result lost or changed")

endmodule
